// File: rtl/core/frp_pkg.sv
// frp_pkg: shared types, constants and helpers of the fasta record stream parser
// used by every file under rtl/core; depends on nothing
package frp_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 3;
   localparam int REG_LSB    = 3;
   localparam logic [REG_IDX_W-1:0] REG_MASK0  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MASK1  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MASK2  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MASK3  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_REPORT = 3'd4;
   localparam int MASK_WORDS = 4;
   localparam int MASK_W     = 256;

   // result kinds
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_SYMBOL  = 3'd1;
   localparam logic [2:0] KIND_COMMENT = 3'd2;
   localparam logic [2:0] KIND_CMT_END = 3'd3;
   localparam logic [2:0] KIND_IGNORED = 3'd4;
   localparam logic [2:0] KIND_REC_END = 3'd5;

   // special bytes
   localparam logic [7:0] CH_MONO      = 8'h3E;
   localparam logic [7:0] CH_MULTI     = 8'h3B;
   localparam logic [7:0] CH_COMMENT   = 8'h3B;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_EOF       = 8'hFF;
   localparam logic [7:0] CH_BLANK_MAX = 8'h20;

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  value;
      logic [31:0] seq_position;
      logic [31:0] line_number;
      logic [15:0] column;
      logic        last;
   } rsp_item_type;

   // results of one input byte, one or two
   typedef struct packed {
      logic         two;
      rsp_item_type first;
      rsp_item_type second;
   } pkt_type;

   typedef struct packed {
      logic              full;
      logic              nonempty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic out_valid;
      logic sec_valid;
   } back_status_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

// File: rtl/core/frp_csr.sv
// frp_csr: apb-style register file holding the legal symbol mask and report flag
// depends on frp_pkg
module frp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [frp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [frp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [frp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [frp_pkg::MASK_W-1:0]      legal_mask,
   output logic                            report_ignored
);
   import frp_pkg::*;

   logic [CSR_DATA_W-1:0] mask_ff [MASK_WORDS];
   logic [CSR_DATA_W-1:0] mask_in [MASK_WORDS];
   logic                  report_ff, report_in;
   logic [REG_IDX_W-1:0]  idx;
   logic                  wr;

   assign pready = 1'b1;
   assign idx    = paddr[REG_LSB +: REG_IDX_W];
   assign wr     = psel & penable & pwrite;

   always_comb begin
      mask_in   = mask_ff;
      report_in = report_ff;
      if (wr) begin
         unique case (idx)
            REG_MASK0:  mask_in[0] = pwdata;
            REG_MASK1:  mask_in[1] = pwdata;
            REG_MASK2:  mask_in[2] = pwdata;
            REG_MASK3:  mask_in[3] = pwdata;
            REG_REPORT: report_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MASK0:  prdata = mask_ff[0];
         REG_MASK1:  prdata = mask_ff[1];
         REG_MASK2:  prdata = mask_ff[2];
         REG_MASK3:  prdata = mask_ff[3];
         REG_REPORT: prdata = {{(CSR_DATA_W-1){1'b0}}, report_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MASK_WORDS; i++) mask_ff[i] <= '0;
         report_ff <= 1'b0;
      end else begin
         mask_ff   <= mask_in;
         report_ff <= report_in;
      end
   end

   assign legal_mask     = {mask_ff[3], mask_ff[2], mask_ff[1], mask_ff[0]};
   assign report_ignored = report_ff;

endmodule

// File: rtl/core/frp_front.sv
// frp_front: parser state and byte classification, builds the result pair per byte
// depends on frp_pkg
module frp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  frp_pkg::req_item_type       item,
   input  logic [frp_pkg::MASK_W-1:0]  legal_mask,
   input  logic                        report_ignored,
   output logic                        pkt_push,
   output frp_pkg::pkt_type            pkt
);
   import frp_pkg::*;

   logic        line_start_ff, line_start_in;
   logic        header_ff, header_in;
   logic        seq_ff, seq_in;
   logic        comment_ff, comment_in;
   logic [31:0] sym_ff, sym_in;
   logic [31:0] line_ff, line_in;
   logic [15:0] col_ff, col_in;

   logic [7:0]   c;
   logic         eoi, is_mark, is_blank, is_lf, pre_v, main_v, post_v;
   logic         hdr1, seq1, cmt1, cmt2;
   logic [31:0]  sym1, sym2, line1;
   logic [15:0]  col1;
   logic [2:0]   main_kind;
   rsp_item_type r_pre, r_main, r_post;

   always_comb begin
      eoi      = item.end_of_input;
      c        = (eoi || item.in_byte == CH_EOF) ? CH_LF : item.in_byte;
      is_mark  = (c == CH_MONO) || (c == CH_MULTI);
      is_lf    = (c == CH_LF);
      is_blank = (c != 8'd0) && (c <= CH_BLANK_MAX);

      // record end when a new header opens while a sequence is open
      pre_v = line_start_ff && is_mark && seq_ff;
      hdr1  = (line_start_ff && is_mark) ? 1'b1 : ((line_start_ff && header_ff) ? 1'b0 : header_ff);
      seq1  = pre_v ? 1'b0 : ((line_start_ff && !is_mark && header_ff) ? 1'b1 : seq_ff);
      cmt1  = pre_v ? 1'b0 : comment_ff;
      sym1  = pre_v ? 32'd0 : sym_ff;
      line1 = line_start_ff ? sat_inc32(line_ff) : line_ff;
      col1  = sat_inc16(line_start_ff ? 16'd0 : col_ff);

      main_v    = 1'b0;
      main_kind = KIND_HEADER;
      cmt2      = cmt1;
      sym2      = sym1;
      if (hdr1) begin
         main_v = 1'b1;
      end else if (seq1) begin
         if (cmt1) begin
            main_v = 1'b1;
            if (is_lf) begin
               cmt2      = 1'b0;
               main_kind = KIND_CMT_END;
            end else begin
               main_kind = KIND_COMMENT;
            end
         end else if (c == CH_COMMENT) begin
            cmt2 = 1'b1;
         end else if (is_blank) begin
            main_v = 1'b0;
         end else if (legal_mask[c]) begin
            main_v    = 1'b1;
            main_kind = KIND_SYMBOL;
            sym2      = sat_inc32(sym1);
         end else if (report_ignored) begin
            main_v    = 1'b1;
            main_kind = KIND_IGNORED;
         end
      end
      post_v = eoi && (hdr1 || seq1);

      r_pre  = '{kind: KIND_REC_END, value: 8'd0, seq_position: sym_ff,
                 line_number: line_ff, column: 16'd0, last: 1'b0};
      r_main = '{kind: main_kind, value: c, seq_position: sym2,
                 line_number: line1, column: col1, last: !post_v};
      r_post = '{kind: KIND_REC_END, value: 8'd0, seq_position: sym2,
                 line_number: line1, column: 16'd0, last: 1'b1};

      if (pre_v) begin
         pkt.two    = 1'b1;
         pkt.first  = r_pre;
         pkt.second = r_main;
      end else begin
         pkt.two    = main_v && post_v;
         pkt.first  = main_v ? r_main : r_post;
         pkt.second = r_post;
      end
      pkt_push = accept && (pre_v || main_v || post_v);

      line_start_in = line_start_ff;
      header_in     = header_ff;
      seq_in        = seq_ff;
      comment_in    = comment_ff;
      sym_in        = sym_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      if (accept) begin
         if (eoi) begin
            line_start_in = 1'b1;
            header_in     = 1'b0;
            seq_in        = 1'b0;
            comment_in    = 1'b0;
            sym_in        = 32'd0;
            line_in       = 32'd0;
            col_in        = 16'd0;
         end else begin
            line_start_in = is_lf;
            header_in     = hdr1;
            seq_in        = seq1;
            comment_in    = cmt2;
            sym_in        = sym2;
            line_in       = line1;
            col_in        = col1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff <= 1'b1;
         header_ff     <= 1'b0;
         seq_ff        <= 1'b0;
         comment_ff    <= 1'b0;
         sym_ff        <= 32'd0;
         line_ff       <= 32'd0;
         col_ff        <= 16'd0;
      end else begin
         line_start_ff <= line_start_in;
         header_ff     <= header_in;
         seq_ff        <= seq_in;
         comment_ff    <= comment_in;
         sym_ff        <= sym_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
      end
   end

endmodule

// File: rtl/core/frp_queue.sv
// frp_queue: short queue of result pairs between the front and the back
// depends on frp_pkg
module frp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  frp_pkg::pkt_type          wr_pkt,
   input  logic                      rd_en,
   output frp_pkg::pkt_type          rd_pkt,
   output frp_pkg::queue_status_type status
);
   import frp_pkg::*;

   pkt_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr, do_rd;

   assign status.full     = (count_ff == QCNT_W'(QDEPTH));
   assign status.nonempty = (count_ff != '0);
   assign status.count    = count_ff;
   assign rd_pkt          = entry_ff[rd_ptr_ff];

   always_comb begin
      do_wr     = wr_en && !status.full;
      do_rd     = rd_en && status.nonempty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      if (do_rd)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      if (do_wr && !do_rd)
         count_in = count_ff + QCNT_W'(1);
      else if (do_rd && !do_wr)
         count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) entry_ff[wr_ptr_ff] <= wr_pkt;
   end

endmodule

// File: rtl/core/frp_back.sv
// frp_back: splits queued result pairs into single results on the output register
// depends on frp_pkg
module frp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  frp_pkg::pkt_type         q_pkt,
   input  logic                     q_nonempty,
   output logic                     q_pop,
   input  logic                     pop,
   output logic                     empty,
   output frp_pkg::rsp_item_type    rsp_item,
   output frp_pkg::back_status_type status
);
   import frp_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         sec_valid_ff, sec_valid_in;
   rsp_item_type out_ff, out_in;
   rsp_item_type sec_ff, sec_in;
   logic         advance;

   always_comb begin
      advance      = !out_valid_ff || pop;
      q_pop        = advance && !sec_valid_ff && q_nonempty;
      out_valid_in = out_valid_ff;
      sec_valid_in = sec_valid_ff;
      out_in       = out_ff;
      sec_in       = sec_ff;
      if (advance) begin
         if (sec_valid_ff) begin
            // second result of a pair goes before the next pair
            out_in       = sec_ff;
            out_valid_in = 1'b1;
            sec_valid_in = 1'b0;
         end else if (q_nonempty) begin
            out_in       = q_pkt.first;
            out_valid_in = 1'b1;
            sec_in       = q_pkt.second;
            sec_valid_in = q_pkt.two;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sec_ff <= sec_in;
   end

   assign empty            = !out_valid_ff;
   assign rsp_item         = out_ff;
   assign status.out_valid = out_valid_ff;
   assign status.sec_valid = sec_valid_ff;

endmodule

// File: rtl/core/fasta_record_stream_parser.sv
// fasta_record_stream_parser: top level, ties register file, front, queue and back
// depends on frp_pkg, frp_csr, frp_front, frp_queue, frp_back
//
//   channel   handshake            payload
//   request   push / full          req_item  (in_byte, end_of_input)
//   response  pop / empty          rsp_item  (kind, value, seq_position, line_number,
//                                             column, last)
//   csr       psel penable pwrite  paddr, pwdata, prdata (64 bit, register i at 8*i)
//
// one byte is accepted per cycle while the four-entry pair queue has room
// a byte gives zero, one or two results; the output register hands out one per cycle
// while pop is high; a second result waits in the back and the queue absorbs bursts
// the first result of a byte passes the pair queue and then the output register
// reset is synchronous and clears parser state, queue and registers
// full follows the queue only, empty follows the output register only
module fasta_record_stream_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  frp_pkg::req_item_type           req_item,
   output logic                            empty,
   input  logic                            pop,
   output frp_pkg::rsp_item_type           rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [frp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [frp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [frp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import frp_pkg::*;

   logic [MASK_W-1:0] legal_mask;
   logic              report_ignored;
   logic              accept, pkt_push, q_pop;
   pkt_type           pkt, q_pkt;
   queue_status_type  q_status;
   back_status_type   b_status;

   assign full   = q_status.full;
   assign accept = push && !q_status.full;

   frp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .legal_mask     (legal_mask),
      .report_ignored (report_ignored)
   );

   frp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .item           (req_item),
      .legal_mask     (legal_mask),
      .report_ignored (report_ignored),
      .pkt_push       (pkt_push),
      .pkt            (pkt)
   );

   frp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (pkt_push),
      .wr_pkt (pkt),
      .rd_en  (q_pop),
      .rd_pkt (q_pkt),
      .status (q_status)
   );

   frp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_pkt      (q_pkt),
      .q_nonempty (q_status.nonempty),
      .q_pop      (q_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp_item   (rsp_item),
      .status     (b_status)
   );

   // queue occupancy stays within its depth
   a_q_count: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QDEPTH))
      else $error("pair queue count beyond depth");

   // a held second result implies a visible first one
   a_sec_needs_out: assert property (@(posedge clock) disable iff (reset)
      b_status.sec_valid |-> b_status.out_valid)
      else $error("second result held without output");

   // first result of a pair never carries the last flag, the second one always does
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (pkt_push && pkt.two) |-> (!pkt.first.last && pkt.second.last))
      else $error("last flag misplaced in result pair");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !b_status.sec_valid && !q_status.nonempty))
      else $error("results visible after reset");

endmodule

// File: test/fasta_parse_checker.sv
`timescale 1ns / 1ps
// fasta_parse_checker: watches the byte, result and register channels of the parser,
// predicts every result from its own copy of the parse state and compares field by field
// depends on frp_pkg
module fasta_parse_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           full,
   input  frp_pkg::req_item_type          req_item,
   input  logic                           pop,
   input  logic                           empty,
   input  frp_pkg::rsp_item_type          rsp_item,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [frp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [frp_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             errors,
   output int                             pending,
   output int                             checked
);
   import frp_pkg::*;

   logic [63:0] legal_words [MASK_WORDS];
   logic        report_bad;

   logic        line_start;
   logic        header_open;
   logic        sequence_open;
   logic        comment_open;
   logic [31:0] symbols_kept;
   logic [31:0] lines_seen;
   logic [15:0] column_now;

   rsp_item_type expected_results [$];
   rsp_item_type made [2];
   int           made_n;
   rsp_item_type oldest;

   task automatic clear_parse_state();
      line_start = 1'b1;
      header_open = 1'b0;
      sequence_open = 1'b0;
      comment_open = 1'b0;
      symbols_kept = 32'd0;
      lines_seen = 32'd0;
      column_now = 16'd0;
   endtask

   task automatic add_result(input logic [2:0] kind, input logic [7:0] value,
                             input logic [15:0] col);
      rsp_item_type r;
      r.kind = kind;
      r.value = value;
      r.seq_position = symbols_kept;
      r.line_number = lines_seen;
      r.column = col;
      r.last = 1'b0;
      made[made_n] = r;
      made_n++;
   endtask

   task automatic classify_byte(input req_item_type item);
      logic [7:0] c;
      c = item.in_byte;
      made_n = 0;
      if (item.end_of_input || c == CH_EOF) c = CH_LF;

      if (line_start) begin
         if (c == CH_MONO || c == CH_MULTI) begin
            // a header mark closes the open record first
            if (sequence_open) begin
               add_result(KIND_REC_END, 8'd0, 16'd0);
               sequence_open = 1'b0;
               comment_open = 1'b0;
               symbols_kept = 32'd0;
            end
            header_open = 1'b1;
         end else if (header_open) begin
            header_open = 1'b0;
            sequence_open = 1'b1;
         end
         column_now = 16'd0;
         if (lines_seen != 32'hFFFF_FFFF) lines_seen++;
      end

      if (column_now != 16'hFFFF) column_now++;

      if (header_open) begin
         add_result(KIND_HEADER, c, column_now);
      end else if (sequence_open) begin
         if (comment_open) begin
            if (c == CH_LF) begin
               comment_open = 1'b0;
               add_result(KIND_CMT_END, c, column_now);
            end else begin
               add_result(KIND_COMMENT, c, column_now);
            end
         end else if (c == CH_COMMENT) begin
            comment_open = 1'b1;
         end else if (c >= 8'd1 && c <= CH_BLANK_MAX) begin
            // blank, nothing to report
         end else if (legal_words[c[7:6]][c[5:0]]) begin
            if (symbols_kept != 32'hFFFF_FFFF) symbols_kept++;
            add_result(KIND_SYMBOL, c, column_now);
         end else if (report_bad) begin
            add_result(KIND_IGNORED, c, column_now);
         end
      end

      line_start = (c == CH_LF);

      if (item.end_of_input) begin
         if (header_open || sequence_open) add_result(KIND_REC_END, 8'd0, 16'd0);
         clear_parse_state();
      end

      for (int i = 0; i < made_n; i++) begin
         if (i == made_n - 1) made[i].last = 1'b1;
         expected_results.push_back(made[i]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MASK_WORDS; k++) legal_words[k] = 64'd0;
         report_bad = 1'b0;
         clear_parse_state();
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[REG_LSB +: REG_IDX_W])
               REG_MASK0:  legal_words[0] = pwdata;
               REG_MASK1:  legal_words[1] = pwdata;
               REG_MASK2:  legal_words[2] = pwdata;
               REG_MASK3:  legal_words[3] = pwdata;
               REG_REPORT: report_bad = pwdata[0];
               default: ;
            endcase
         end

         // results first: nothing accepted at this edge can already be on the output
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d value %0d", rsp_item.kind,
                      rsp_item.value);
               errors++;
            end else begin
               oldest = expected_results.pop_front();
               checked++;
               if (rsp_item.kind !== oldest.kind) begin
                  $error("kind: expected %0d, got %0d", oldest.kind, rsp_item.kind);
                  errors++;
               end
               if (rsp_item.value !== oldest.value) begin
                  $error("value: expected %0d, got %0d", oldest.value, rsp_item.value);
                  errors++;
               end
               if (rsp_item.seq_position !== oldest.seq_position) begin
                  $error("seq_position: expected %0d, got %0d", oldest.seq_position,
                         rsp_item.seq_position);
                  errors++;
               end
               if (rsp_item.line_number !== oldest.line_number) begin
                  $error("line_number: expected %0d, got %0d", oldest.line_number,
                         rsp_item.line_number);
                  errors++;
               end
               if (rsp_item.column !== oldest.column) begin
                  $error("column: expected %0d, got %0d", oldest.column, rsp_item.column);
                  errors++;
               end
               if (rsp_item.last !== oldest.last) begin
                  $error("last: expected %0d, got %0d", oldest.last, rsp_item.last);
                  errors++;
               end
            end
         end

         if (push && !full) classify_byte(req_item);
      end
      pending = expected_results.size();
   end

endmodule

// File: test/fasta_record_stream_parser_test.sv
`timescale 1ns / 1ps
// fasta_record_stream_parser_test: drives byte streams and register writes into the parser
// and gives the verdict; depends on frp_pkg, fasta_record_stream_parser, fasta_parse_checker
module fasta_record_stream_parser_test;
   import frp_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   // directed opening: bit 8 marks end of input
   localparam logic [8:0] OPENING [25] = '{
      9'h078, 9'h020, 9'h03E, 9'h068, 9'h000, 9'h0FF, 9'h03B, 9'h06D, 9'h00A,
      9'h041, 9'h020, 9'h001, 9'h021, 9'h000, 9'h0FE, 9'h03B, 9'h071, 9'h00A,
      9'h03B, 9'h072, 9'h00A, 9'h063, 9'h067, 9'h141, 9'h100
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   req_item_type          req_item = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   rsp_item_type          rsp_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int          errors;
   int          pending;
   int          checked;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          bytes_sent = 0;
   int          files_ended = 0;
   int          quiet_cycles = 0;
   logic        file_open = 1'b0;
   logic [255:0] legal_set = '0;
   logic [255:0] dna_set = '0;

   fasta_record_stream_parser dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   fasta_parse_checker u_checker (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_item(req_item),
      .pop(pop), .empty(empty), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .errors(errors), .pending(pending), .checked(checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: random stalls
   always @(negedge clock) begin
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("fasta_record_stream_parser_test: errors");
         $finish;
      end
   end

   function automatic logic [7:0] line_end();
      return ($urandom_range(0, 99) < 80) ? CH_LF : CH_EOF;
   endfunction

   function automatic logic [255:0] random_mask();
      logic [255:0] m;
      m = '0;
      m[8'h41] = 1'b1;
      repeat ($urandom_range(4, 16)) m[8'($urandom_range(0, 255))] = 1'b1;
      return m;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eoi);
      req_item_type staged;
      staged.in_byte = b;
      staged.end_of_input = eoi;
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_item <= staged;
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
      if (eoi) files_ended++;
   endtask

   // lower push, let expected results drain, then give the pipeline time to empty
   task automatic wait_drained(input int extra);
      @(negedge clock);
      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, {REG_LSB{1'b0}}};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic program_parser(input logic [255:0] mask, input logic report);
      wait_drained(8);
      csr_write(REG_MASK0, mask[63:0]);
      csr_write(REG_MASK1, mask[127:64]);
      csr_write(REG_MASK2, mask[191:128]);
      csr_write(REG_MASK3, mask[255:192]);
      csr_write(REG_REPORT, {63'd0, report});
      legal_set = mask;
   endtask

   // mostly well-formed records with random content, some noise lines and file ends
   task automatic send_random_text(input int budget);
      int         target;
      int         r;
      int         len;
      int         pick;
      logic [7:0] b;
      logic       found;
      target = bytes_sent + budget;
      while (bytes_sent < target) begin
         r = $urandom_range(0, 99);
         if (!file_open && r < 85) r = 0;
         if (r < 12) begin
            send_byte(($urandom_range(0, 1) == 0) ? CH_MONO : CH_MULTI, 1'b0);
            len = $urandom_range(0, 10);
            repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(line_end(), 1'b0);
            file_open = 1'b1;
         end else if (r < 82) begin
            len = $urandom_range(0, 24);
            repeat (len) begin
               pick = $urandom_range(0, 99);
               if (pick < 65) begin
                  found = 1'b0;
                  b = 8'h41;
                  for (int t = 0; t < 16 && !found; t++) begin
                     b = 8'($urandom_range(0, 255));
                     found = legal_set[b];
                  end
                  if (!found) b = 8'h41;
               end else if (pick < 75) begin
                  b = 8'($urandom_range(1, 32));
               end else if (pick < 87) begin
                  b = 8'($urandom_range(0, 255));
               end else if (pick < 93) begin
                  b = CH_COMMENT;
               end else begin
                  b = 8'h00;
               end
               send_byte(b, 1'b0);
            end
            send_byte(line_end(), 1'b0);
         end else if (r < 90) begin
            len = $urandom_range(0, 16);
            repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end else if (r < 95) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            file_open = 1'b0;
         end else begin
            send_byte(line_end(), 1'b0);
         end
      end
   endtask

   initial begin
      dna_set[8'h41] = 1'b1;
      dna_set[8'h43] = 1'b1;
      dna_set[8'h47] = 1'b1;
      dna_set[8'h54] = 1'b1;
      dna_set[8'h4E] = 1'b1;
      dna_set[8'h61] = 1'b1;
      dna_set[8'h63] = 1'b1;
      dna_set[8'h67] = 1'b1;
      dna_set[8'h74] = 1'b1;
      dna_set[8'h6E] = 1'b1;
      dna_set[8'h21] = 1'b1;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 37;
      rx_idle_pct = 74;
      program_parser(dna_set, 1'b1);
      foreach (OPENING[i]) send_byte(OPENING[i][7:0], OPENING[i][8]);
      file_open = 1'b0;
      program_parser(random_mask(), 1'b1);
      send_random_text(400);

      tx_idle_pct = 74;
      rx_idle_pct = 37;
      program_parser('1, 1'b0);
      send_random_text(400);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      program_parser('0, 1'b1);
      send_random_text(200);
      program_parser(random_mask(), 1'b0);
      send_random_text(200);

      wait_drained(16);
      $display("sent %0d bytes in %0d files over five register settings, %0d results compared",
               bytes_sent, files_ended, checked);
      $display("stalls on both sides, comments, ignored symbols and record ends included");
      if (errors == 0)
         $display("fasta_record_stream_parser_test: clean");
      else
         $display("fasta_record_stream_parser_test: errors");
      $finish;
   end

endmodule
